@@ design/hjc_pkg.sv @@
// ----------------------------------------------------------------------------
// hjc_pkg
// Shared types, phase codes and jamo lookup functions of the syllable composer.
// ----------------------------------------------------------------------------
package hjc_pkg;

  localparam logic [3:0] PH_INIT     = 4'd0;
  localparam logic [3:0] PH_VOWEL    = 4'd1;
  localparam logic [3:0] PH_AFTER_O  = 4'd2;
  localparam logic [3:0] PH_AFTER_U  = 4'd3;
  localparam logic [3:0] PH_AFTER_EU = 4'd4;
  localparam logic [3:0] PH_FINAL    = 4'd5;
  localparam logic [3:0] PH_HELD     = 4'd6;

  localparam int QDEPTH = 2;

  typedef struct packed {
    logic        syl;
    logic        err;
    logic [15:0] cp;
  } hjc_cmd_t;

  // initial number + 1, zero when the jamo cannot be an initial
  function automatic logic [4:0] init_num(input logic [5:0] j);
    logic [4:0] r;
    case (j)
      6'd0:  r = 5'd1;
      6'd1:  r = 5'd2;
      6'd3:  r = 5'd3;
      6'd6:  r = 5'd4;
      6'd7:  r = 5'd5;
      6'd8:  r = 5'd6;
      6'd16: r = 5'd7;
      6'd17: r = 5'd8;
      6'd18: r = 5'd9;
      6'd20: r = 5'd10;
      6'd21: r = 5'd11;
      6'd22: r = 5'd12;
      6'd23: r = 5'd13;
      6'd24: r = 5'd14;
      6'd25: r = 5'd15;
      6'd26: r = 5'd16;
      6'd27: r = 5'd17;
      6'd28: r = 5'd18;
      6'd29: r = 5'd19;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

  // vowel number + 1, zero when the jamo is not a simple vowel
  function automatic logic [4:0] vowel_num(input logic [5:0] j);
    logic [4:0] r;
    case (j)
      6'd30: r = 5'd1;
      6'd31: r = 5'd2;
      6'd32: r = 5'd3;
      6'd33: r = 5'd4;
      6'd34: r = 5'd5;
      6'd35: r = 5'd6;
      6'd36: r = 5'd7;
      6'd37: r = 5'd8;
      6'd38: r = 5'd9;
      6'd42: r = 5'd13;
      6'd43: r = 5'd14;
      6'd47: r = 5'd18;
      6'd48: r = 5'd19;
      6'd50: r = 5'd21;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

  // single final number, zero when the jamo cannot be a final
  function automatic logic [4:0] final_num(input logic [5:0] j);
    logic [4:0] r;
    case (j)
      6'd0:  r = 5'd1;
      6'd1:  r = 5'd2;
      6'd3:  r = 5'd4;
      6'd6:  r = 5'd7;
      6'd8:  r = 5'd8;
      6'd16: r = 5'd16;
      6'd17: r = 5'd17;
      6'd20: r = 5'd19;
      6'd21: r = 5'd20;
      6'd22: r = 5'd21;
      6'd23: r = 5'd22;
      6'd25: r = 5'd23;
      6'd26: r = 5'd24;
      6'd27: r = 5'd25;
      6'd28: r = 5'd26;
      6'd29: r = 5'd27;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] vowel_phase(input logic [5:0] j);
    logic [3:0] r;
    case (j)
      6'd38:   r = PH_AFTER_O;
      6'd43:   r = PH_AFTER_U;
      6'd48:   r = PH_AFTER_EU;
      default: r = PH_FINAL;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] vowel_add(input logic [3:0] ph, input logic [5:0] j);
    logic [1:0] r;
    r = 2'd0;
    if (ph == PH_AFTER_O) begin
      if (j == 6'd30) r = 2'd1;
      else if (j == 6'd31) r = 2'd2;
      else if (j == 6'd50) r = 2'd3;
    end else if (ph == PH_AFTER_U) begin
      if (j == 6'd34) r = 2'd1;
      else if (j == 6'd35) r = 2'd2;
      else if (j == 6'd50) r = 2'd3;
    end else if (j == 6'd50) begin
      r = 2'd1;
    end
    return r;
  endfunction

  function automatic logic [4:0] compound_final(input logic [5:0] c, input logic [5:0] d);
    logic [4:0] r;
    r = 5'd0;
    case (c)
      6'd0: begin
        if (d == 6'd20) r = 5'd3;
      end
      6'd3: begin
        if (d == 6'd23) r = 5'd5;
        else if (d == 6'd29) r = 5'd6;
      end
      6'd8: begin
        case (d)
          6'd0:    r = 5'd9;
          6'd16:   r = 5'd10;
          6'd17:   r = 5'd11;
          6'd20:   r = 5'd12;
          6'd27:   r = 5'd13;
          6'd28:   r = 5'd14;
          6'd29:   r = 5'd15;
          default: r = 5'd0;
        endcase
      end
      6'd17: begin
        if (d == 6'd20) r = 5'd18;
      end
      default: r = 5'd0;
    endcase
    return r;
  endfunction

endpackage

@@ design/hjc_front.sv @@
// ----------------------------------------------------------------------------
// hjc_front
// Accepts jamo, runs the composition state and queues at most one command per item.
// ----------------------------------------------------------------------------
module hjc_front
  import hjc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [5:0] in_jamo_index,
  input  logic       in_flush,
  input  logic       q_full,
  output logic       q_push,
  output hjc_cmd_t   q_cmd
);

  logic [3:0] phase_r, phase_nxt;
  logic [4:0] init_r, init_nxt;
  logic [4:0] vow_r, vow_nxt;
  logic [4:0] fin_r, fin_nxt;
  logic [5:0] held_r, held_nxt;

  logic       accept;
  logic       syl, err;
  logic [4:0] z;
  logic [4:0] ti, tv, tf, tc, th;
  logic [1:0] ta;
  logic [15:0] cp;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  assign ti = init_num(in_jamo_index);
  assign tv = vowel_num(in_jamo_index);
  assign tf = final_num(in_jamo_index);
  assign ta = vowel_add(phase_r, in_jamo_index);
  assign tc = compound_final(held_r, in_jamo_index);
  assign th = init_num(held_r);

  always_comb begin
    syl       = 1'b0;
    err       = 1'b0;
    z         = 5'd0;
    phase_nxt = phase_r;
    init_nxt  = init_r;
    vow_nxt   = vow_r;
    fin_nxt   = fin_r;
    held_nxt  = held_r;
    if (in_flush) begin
      case (phase_r)
        PH_VOWEL: err = 1'b1;
        PH_AFTER_O, PH_AFTER_U, PH_AFTER_EU, PH_FINAL: syl = 1'b1;
        PH_HELD: begin
          syl = 1'b1;
          z   = fin_r;
        end
        default: syl = 1'b0;
      endcase
      phase_nxt = PH_INIT;
    end else begin
      case (phase_r)
        PH_VOWEL: begin
          if (tv != 5'd0) begin
            vow_nxt   = tv - 5'd1;
            phase_nxt = vowel_phase(in_jamo_index);
          end else begin
            err = 1'b1;
            if (ti != 5'd0) begin
              init_nxt  = ti - 5'd1;
              phase_nxt = PH_VOWEL;
            end else begin
              phase_nxt = PH_INIT;
            end
          end
        end
        PH_AFTER_O, PH_AFTER_U, PH_AFTER_EU, PH_FINAL: begin
          if (phase_r != PH_FINAL && ta != 2'd0) begin
            vow_nxt   = vow_r + {3'd0, ta};
            phase_nxt = PH_FINAL;
          end else if (tf != 5'd0) begin
            held_nxt  = in_jamo_index;
            fin_nxt   = tf;
            phase_nxt = PH_HELD;
          end else begin
            syl = 1'b1;
            if (ti != 5'd0) begin
              init_nxt  = ti - 5'd1;
              phase_nxt = PH_VOWEL;
            end else begin
              err       = 1'b1;
              phase_nxt = PH_INIT;
            end
          end
        end
        PH_HELD: begin
          syl = 1'b1;
          if (tv != 5'd0) begin
            init_nxt  = (th != 5'd0) ? th - 5'd1 : 5'd0;
            vow_nxt   = tv - 5'd1;
            phase_nxt = vowel_phase(in_jamo_index);
          end else if (tc != 5'd0) begin
            z         = tc;
            phase_nxt = PH_INIT;
          end else begin
            z = fin_r;
            if (ti != 5'd0) begin
              init_nxt  = ti - 5'd1;
              phase_nxt = PH_VOWEL;
            end else begin
              err       = 1'b1;
              phase_nxt = PH_INIT;
            end
          end
        end
        default: begin
          if (ti != 5'd0) begin
            init_nxt  = ti - 5'd1;
            phase_nxt = PH_VOWEL;
          end else begin
            err       = 1'b1;
            phase_nxt = PH_INIT;
          end
        end
      endcase
    end
  end

  assign cp = 16'hAC00 + (16'(init_r) * 16'd588) + (16'(vow_r) * 16'd28) + 16'(z);

  assign q_push    = accept && (syl || err);
  assign q_cmd.syl = syl;
  assign q_cmd.err = err;
  assign q_cmd.cp  = cp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_INIT;
      init_r  <= 5'd0;
      vow_r   <= 5'd0;
      fin_r   <= 5'd0;
      held_r  <= 6'd0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      init_r  <= init_nxt;
      vow_r   <= vow_nxt;
      fin_r   <= fin_nxt;
      held_r  <= held_nxt;
    end
  end

endmodule

@@ design/hjc_queue.sv @@
// ----------------------------------------------------------------------------
// hjc_queue
// Short command queue between the composer front and the byte back end.
// ----------------------------------------------------------------------------
module hjc_queue
  import hjc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  hjc_cmd_t push_cmd,
  output logic     full,
  input  logic     pop,
  output logic     q_valid,
  output hjc_cmd_t pop_cmd
);

  localparam int PW = $clog2(QDEPTH);

  hjc_cmd_t        mem_r [QDEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [PW:0]     cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign full    = (cnt_r == (PW+1)'(QDEPTH));
  assign q_valid = (cnt_r != '0);
  assign pop_cmd = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    else if (do_pop && !do_push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= (wr_ptr_r == PW'(QDEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
      if (do_pop) rd_ptr_r <= (rd_ptr_r == PW'(QDEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (PW+1)'(QDEPTH))
    else $error("queue count beyond depth");

  a_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push && full |=> cnt_r == (PW+1)'(QDEPTH) || $past(do_pop))
    else $error("queue lost an entry");

endmodule

@@ design/hjc_back.sv @@
// ----------------------------------------------------------------------------
// hjc_back
// Expands queued commands into UTF-8 bytes and error items on the output.
// ----------------------------------------------------------------------------
module hjc_back
  import hjc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  input  hjc_cmd_t   q_cmd,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_utf8_byte,
  output logic       out_error_flag,
  output logic       out_last_of_run
);

  localparam logic [1:0] STEP_B0  = 2'd0;
  localparam logic [1:0] STEP_B1  = 2'd1;
  localparam logic [1:0] STEP_B2  = 2'd2;
  localparam logic [1:0] STEP_ERR = 2'd3;

  logic        ent_valid_r;
  logic        ent_err_r;
  logic [15:0] ent_cp_r;
  logic [1:0]  step_r;

  logic        out_valid_r;
  logic [7:0]  out_byte_r;
  logic        out_err_r;
  logic        out_last_r;

  logic        out_free, fire, last, ent_done;
  logic [7:0]  byte_val;

  assign out_free = !out_valid_r || out_ready;
  assign fire     = ent_valid_r && out_free;
  assign last     = (step_r == STEP_ERR) || (step_r == STEP_B2 && !ent_err_r);
  assign ent_done = fire && last;
  assign q_pop    = q_valid && (!ent_valid_r || ent_done);

  always_comb begin
    case (step_r)
      STEP_B0: byte_val = {4'hE, ent_cp_r[15:12]};
      STEP_B1: byte_val = {2'b10, ent_cp_r[11:6]};
      STEP_B2: byte_val = {2'b10, ent_cp_r[5:0]};
      default: byte_val = 8'h00;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_valid_r <= 1'b0;
      step_r      <= STEP_B0;
    end else if (q_pop) begin
      ent_valid_r <= 1'b1;
      step_r      <= q_cmd.syl ? STEP_B0 : STEP_ERR;
    end else if (ent_done) begin
      ent_valid_r <= 1'b0;
    end else if (fire) begin
      step_r <= (step_r == STEP_B2) ? STEP_ERR : step_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      ent_err_r <= q_cmd.err;
      ent_cp_r  <= q_cmd.cp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_byte_r <= byte_val;
      out_err_r  <= (step_r == STEP_ERR);
      out_last_r <= last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_utf8_byte   = out_byte_r;
  assign out_error_flag  = out_err_r;
  assign out_last_of_run = out_last_r;

  a_err_step: assert property (@(posedge clk) disable iff (!rst_n)
    ent_valid_r && step_r == STEP_ERR |-> ent_err_r)
    else $error("error step without pending error");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_err_r |-> out_byte_r == 8'h00 && out_last_r)
    else $error("error item carries data or is not last");

  a_lead_byte: assert property (@(posedge clk) disable iff (!rst_n)
    fire && step_r == STEP_B0 |=> out_byte_r[7:4] == 4'hE && !out_last_r)
    else $error("bad lead byte");

endmodule

@@ design/hangul_jamo_composer.sv @@
// ----------------------------------------------------------------------------
// hangul_jamo_composer
// Composes Hangul syllables from a jamo stream and emits them as UTF-8 bytes.
// The first result of an item passes the command queue, the entry register
// and the output register. Input takes one jamo per cycle while the
// two-entry command queue has room. Output gives one byte per cycle while
// out_ready is high: a syllable gives three bytes, an error item one zero byte.
// Reset (synchronous, rst_n low) clears the composition state and queue.
// ----------------------------------------------------------------------------
module hangul_jamo_composer
  import hjc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [5:0] in_jamo_index,
  input  logic       in_flush,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_utf8_byte,
  output logic       out_error_flag,
  output logic       out_last_of_run
);

  hjc_cmd_t push_cmd, pop_cmd;
  logic     push, full, pop, q_valid;

  hjc_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_jamo_index (in_jamo_index),
    .in_flush      (in_flush),
    .q_full        (full),
    .q_push        (push),
    .q_cmd         (push_cmd)
  );

  hjc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (full),
    .pop      (pop),
    .q_valid  (q_valid),
    .pop_cmd  (pop_cmd)
  );

  hjc_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_cmd           (pop_cmd),
    .q_pop           (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_utf8_byte   (out_utf8_byte),
    .out_error_flag  (out_error_flag),
    .out_last_of_run (out_last_of_run)
  );

endmodule

@@ dv/hjc_syllable_check.sv @@
// ----------------------------------------------------------------------------
// hjc_syllable_check
// Watches both channels of the syllable composer, predicts the UTF-8 bytes
// and error items that each accepted jamo causes, and compares every result
// item, field by field, against the oldest prediction still owed.
// ----------------------------------------------------------------------------
module hjc_syllable_check
  import hjc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [5:0] in_jamo_index,
  input  logic       in_flush,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] out_utf8_byte,
  input  logic       out_error_flag,
  input  logic       out_last_of_run,
  output int         mismatches,
  output int         bytes_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [5:0] J_A  = 6'd30;
  localparam logic [5:0] J_AE = 6'd31;
  localparam logic [5:0] J_EO = 6'd34;
  localparam logic [5:0] J_E  = 6'd35;
  localparam logic [5:0] J_O  = 6'd38;
  localparam logic [5:0] J_U  = 6'd43;
  localparam logic [5:0] J_EU = 6'd48;
  localparam logic [5:0] J_I  = 6'd50;

  typedef struct packed {
    logic [7:0] octet;
    logic       err;
    logic       last;
  } utf8_res_t;

  utf8_res_t  owed_q[$];
  logic [3:0] ph;
  logic [4:0] lead_idx;
  logic [4:0] vow_idx;
  logic [4:0] tail_idx;
  logic [5:0] held_j;

  // initial number + 1, zero when j cannot lead a syllable
  function automatic logic [4:0] lead_code(input logic [5:0] j);
    case (j)
      6'd0:  return 5'd1;
      6'd1:  return 5'd2;
      6'd3:  return 5'd3;
      6'd6:  return 5'd4;
      6'd7:  return 5'd5;
      6'd8:  return 5'd6;
      6'd16: return 5'd7;
      6'd17: return 5'd8;
      6'd18: return 5'd9;
      default: return (j >= 6'd20 && j <= 6'd29) ? 5'(j - 6'd10) : 5'd0;
    endcase
  endfunction

  // vowel number + 1, zero unless j is a simple vowel
  function automatic logic [4:0] vowel_code(input logic [5:0] j);
    if ((j >= 6'd30 && j <= 6'd38) || j == 6'd42 || j == J_U || j == 6'd47 ||
        j == J_EU || j == J_I)
      return 5'(j - 6'd29);
    return 5'd0;
  endfunction

  // single final number, zero when j cannot close a syllable
  function automatic logic [4:0] tail_code(input logic [5:0] j);
    case (j)
      6'd0:  return 5'd1;
      6'd1:  return 5'd2;
      6'd3:  return 5'd4;
      6'd6:  return 5'd7;
      6'd8:  return 5'd8;
      6'd16: return 5'd16;
      6'd17: return 5'd17;
      6'd20, 6'd21, 6'd22, 6'd23: return 5'(j - 6'd1);
      default: return (j >= 6'd25 && j <= 6'd29) ? 5'(j - 6'd2) : 5'd0;
    endcase
  endfunction

  function automatic logic [4:0] joint_tail(input logic [5:0] c, input logic [5:0] d);
    case (c)
      6'd0:  return (d == 6'd20) ? 5'd3 : 5'd0;
      6'd3:  return (d == 6'd23) ? 5'd5 : (d == 6'd29) ? 5'd6 : 5'd0;
      6'd8: begin
        case (d)
          6'd0:  return 5'd9;
          6'd16: return 5'd10;
          6'd17: return 5'd11;
          6'd20: return 5'd12;
          6'd27: return 5'd13;
          6'd28: return 5'd14;
          6'd29: return 5'd15;
          default: return 5'd0;
        endcase
      end
      6'd17: return (d == 6'd20) ? 5'd18 : 5'd0;
      default: return 5'd0;
    endcase
  endfunction

  function automatic logic [4:0] vowel_join(input logic [3:0] p, input logic [5:0] j);
    if (p == PH_AFTER_O)
      return (j == J_A) ? 5'd1 : (j == J_AE) ? 5'd2 : (j == J_I) ? 5'd3 : 5'd0;
    if (p == PH_AFTER_U)
      return (j == J_EO) ? 5'd1 : (j == J_E) ? 5'd2 : (j == J_I) ? 5'd3 : 5'd0;
    return (j == J_I) ? 5'd1 : 5'd0;
  endfunction

  task automatic owe_syllable(input logic [4:0] z);
    int         code;
    logic [15:0] cp;
    code = 'hAC00 + 588 * int'(lead_idx) + 28 * int'(vow_idx) + int'(z);
    cp = code[15:0];
    owed_q.push_back('{octet: {4'hE, cp[15:12]}, err: 1'b0, last: 1'b0});
    owed_q.push_back('{octet: {2'b10, cp[11:6]}, err: 1'b0, last: 1'b0});
    owed_q.push_back('{octet: {2'b10, cp[5:0]}, err: 1'b0, last: 1'b0});
  endtask

  task automatic owe_error();
    owed_q.push_back('{octet: 8'h00, err: 1'b1, last: 1'b0});
  endtask

  task automatic take_vowel(input logic [5:0] j);
    vow_idx = vowel_code(j) - 5'd1;
    if (j == J_O)
      ph = PH_AFTER_O;
    else if (j == J_U)
      ph = PH_AFTER_U;
    else if (j == J_EU)
      ph = PH_AFTER_EU;
    else
      ph = PH_FINAL;
  endtask

  task automatic open_syllable(input logic [5:0] j);
    if (lead_code(j) != 5'd0) begin
      lead_idx = lead_code(j) - 5'd1;
      ph = PH_VOWEL;
    end else begin
      ph = PH_INIT;
      owe_error();
    end
  endtask

  task automatic compose(input logic [5:0] j, input logic fl);
    int         n0;
    logic [4:0] v;
    n0 = owed_q.size();
    if (fl) begin
      if (ph == PH_VOWEL)
        owe_error();
      else if (ph >= PH_AFTER_O && ph <= PH_FINAL)
        owe_syllable(5'd0);
      else if (ph == PH_HELD)
        owe_syllable(tail_idx);
      ph = PH_INIT;
    end else if (ph == PH_VOWEL) begin
      if (vowel_code(j) != 5'd0) begin
        take_vowel(j);
      end else begin
        owe_error();
        if (lead_code(j) != 5'd0) begin
          lead_idx = lead_code(j) - 5'd1;
          ph = PH_VOWEL;
        end else begin
          ph = PH_INIT;
        end
      end
    end else if (ph >= PH_AFTER_O && ph <= PH_FINAL) begin
      v = (ph == PH_FINAL) ? 5'd0 : vowel_join(ph, j);
      if (v != 5'd0) begin
        vow_idx = vow_idx + v;
        ph = PH_FINAL;
      end else if (tail_code(j) != 5'd0) begin
        held_j = j;
        tail_idx = tail_code(j);
        ph = PH_HELD;
      end else begin
        owe_syllable(5'd0);
        open_syllable(j);
      end
    end else if (ph == PH_HELD) begin
      if (vowel_code(j) != 5'd0) begin
        owe_syllable(5'd0);
        lead_idx = (lead_code(held_j) != 5'd0) ? lead_code(held_j) - 5'd1 : 5'd0;
        take_vowel(j);
      end else begin
        v = joint_tail(held_j, j);
        if (v != 5'd0) begin
          owe_syllable(v);
          ph = PH_INIT;
        end else begin
          owe_syllable(tail_idx);
          open_syllable(j);
        end
      end
    end else begin
      open_syllable(j);
    end
    if (owed_q.size() > n0)
      owed_q[owed_q.size() - 1].last = 1'b1;
  endtask

  always @(posedge clk) begin
    utf8_res_t want;
    if (!rst_n) begin
      ph = PH_INIT;
      lead_idx = '0;
      vow_idx = '0;
      tail_idx = '0;
      held_j = '0;
      owed_q.delete();
      mismatches = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (owed_q.size() == 0) begin
          $error("unexpected result: utf8_byte %h error_flag %b last_of_run %b",
                 out_utf8_byte, out_error_flag, out_last_of_run);
          mismatches++;
        end else begin
          want = owed_q.pop_front();
          if (out_utf8_byte !== want.octet) begin
            $error("utf8_byte: expected %h, got %h", want.octet, out_utf8_byte);
            mismatches++;
          end
          if (out_error_flag !== want.err) begin
            $error("error_flag: expected %b, got %b", want.err, out_error_flag);
            mismatches++;
          end
          if (out_last_of_run !== want.last) begin
            $error("last_of_run: expected %b, got %b", want.last, out_last_of_run);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready)
        compose(in_jamo_index, in_flush);
    end
    bytes_owed <= owed_q.size();
  end

endmodule

@@ dv/hangul_jamo_composer_tb.sv @@
// ----------------------------------------------------------------------------
// hangul_jamo_composer_tb
// Drives jamo and flush items into the syllable composer: a directed run over
// the corner cases, then mostly well-formed random syllables mixed with noise,
// with random gaps on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
module hangul_jamo_composer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS   = 335;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int SQUEEZE_CYCLES = 80;
  localparam int TAIL_CYCLES    = 100;
  localparam int FLUSH          = -1;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic [5:0] in_jamo_index = '0;
  logic       in_flush = 1'b0;
  logic       out_ready = 1'b0;
  logic       in_ready;
  logic       out_valid;
  logic [7:0] out_utf8_byte;
  logic       out_error_flag;
  logic       out_last_of_run;

  int mismatches;
  int bytes_owed;
  int items_sent = 0;
  bit steady = 1'b0;
  bit squeeze_req = 1'b0;

  int lead_set[19]  = '{0, 1, 3, 6, 7, 8, 16, 17, 18, 20, 21, 22, 23, 24, 25, 26, 27, 28, 29};
  int vowel_set[14] = '{30, 31, 32, 33, 34, 35, 36, 37, 38, 42, 43, 47, 48, 50};
  int tail_set[16]  = '{0, 1, 3, 6, 8, 16, 17, 20, 21, 22, 23, 25, 26, 27, 28, 29};
  int after_o[3]    = '{30, 31, 50};
  int after_u[3]    = '{34, 35, 50};
  int l_pair[7]     = '{0, 16, 17, 20, 27, 28, 29};
  int directed[28]  = '{FLUSH, 30, 63, 2, 0, 1, 2, 0, 39, 29, 38, 30, 8, 0, 0, 30, 3, 30,
                        0, 7, FLUSH, 24, 43, 50, 2, 18, 48, FLUSH};

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  hangul_jamo_composer uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_jamo_index  (in_jamo_index),
    .in_flush       (in_flush),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_utf8_byte  (out_utf8_byte),
    .out_error_flag (out_error_flag),
    .out_last_of_run(out_last_of_run)
  );

  hjc_syllable_check syl_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_jamo_index  (in_jamo_index),
    .in_flush       (in_flush),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_utf8_byte  (out_utf8_byte),
    .out_error_flag (out_error_flag),
    .out_last_of_run(out_last_of_run),
    .mismatches     (mismatches),
    .bytes_owed     (bytes_owed)
  );

  task automatic send(input logic [5:0] j, input logic fl);
    int gap;
    int r;
    gap = 0;
    if (!steady) begin
      r = $urandom_range(0, 99);
      if (r >= 55)
        gap = (r < 90) ? $urandom_range(1, 3) : $urandom_range(8, 30);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_jamo_index <= j;
    in_flush <= fl;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  // receiver: random stalls, plus one long hold-off once the random part starts
  initial begin
    int r;
    int len;
    bit squeezed;
    squeezed = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (squeeze_req && !squeezed) begin
        squeezed = 1'b1;
        out_ready <= 1'b0;
        repeat (SQUEEZE_CYCLES) @(posedge clk);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          out_ready <= 1'b1;
          len = $urandom_range(1, 20);
        end else if (r < 94) begin
          out_ready <= 1'b0;
          len = $urandom_range(1, 3);
        end else begin
          out_ready <= 1'b0;
          len = $urandom_range(10, 40);
        end
        repeat (len) @(posedge clk);
      end
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (!rst_n) @(posedge clk);
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int base;
    int mode;
    int v;
    int f;
    int partner;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed[i])
      send(directed[i] == FLUSH ? 6'($urandom_range(0, 63)) : 6'(directed[i]),
           directed[i] == FLUSH);

    squeeze_req = 1'b1;
    base = items_sent;
    while (items_sent - base < RANDOM_ITEMS) begin
      steady = ($urandom_range(0, 4) == 0);
      mode = $urandom_range(0, 99);
      if (mode < 75) begin
        repeat ($urandom_range(1, 4)) begin
          send(6'(lead_set[$urandom_range(0, 18)]), 1'b0);
          v = vowel_set[$urandom_range(0, 13)];
          send(6'(v), 1'b0);
          if ($urandom_range(0, 1) == 1) begin
            case (v)
              38: send(6'(after_o[$urandom_range(0, 2)]), 1'b0);
              43: send(6'(after_u[$urandom_range(0, 2)]), 1'b0);
              48: send(6'd50, 1'b0);
              default: ;
            endcase
          end
          if ($urandom_range(0, 9) < 6) begin
            f = tail_set[$urandom_range(0, 15)];
            send(6'(f), 1'b0);
            if ($urandom_range(0, 2) == 0) begin
              case (f)
                0:  partner = 20;
                3:  partner = ($urandom_range(0, 1) == 1) ? 23 : 29;
                8:  partner = l_pair[$urandom_range(0, 6)];
                17: partner = 20;
                default: partner = -1;
              endcase
              if (partner >= 0)
                send(6'(partner), 1'b0);
            end
          end
          if ($urandom_range(0, 4) == 0)
            send(6'($urandom_range(0, 63)), 1'b1);
        end
      end else if (mode < 90) begin
        repeat ($urandom_range(1, 4))
          send(6'($urandom_range(0, 63)), $urandom_range(0, 9) == 0);
      end else begin
        send(6'(lead_set[$urandom_range(0, 18)]), 1'b0);
        send(6'($urandom_range(0, 63)), 1'b0);
      end
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (bytes_owed != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && bytes_owed == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
